### rtl/msqd_pkg.sv
// Package for the matrix-scanned quadrature decoder.
// Holds the result item type and the step codes. It has no dependencies.
package msqd_pkg;

    // Step codes, two's complement in two bits.
    localparam logic [1:0] STEP_NONE = 2'b00;
    localparam logic [1:0] STEP_INC  = 2'b01;
    localparam logic [1:0] STEP_DEC  = 2'b11;

    // Field widths of one result item.
    localparam int COL_FIELD_W   = 2;
    localparam int ENC_FIELD_W   = 4;
    localparam int COUNT_FIELD_W = 16;
    localparam int ROW_FIELD_W   = 8;

    // One result item as produced by a cell.
    typedef struct packed {
        logic [1:0]  step;
        logic [15:0] count_value;
        logic [3:0]  encoder_index;
        logic [1:0]  drive_column;
        logic        last_of_tick;
    } result_t;

endpackage

### rtl/msqd_cell.sv
// One cell of the decoder chain: the encoders of one row pair on all columns.
// Depends on msqd_pkg for the result type and step codes.
module msqd_cell import msqd_pkg::*; #(
    parameter int PAIR_INDEX   = 0,
    parameter int PAIR_COUNT   = 4,
    parameter int COLUMN_COUNT = 4,
    parameter int COUNT_BITS   = 16,
    parameter int COL_W        = 2
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   advance,
    input  logic                   tok_valid_in,
    input  logic [COL_W-1:0]       tok_col_in,
    input  logic [ROW_FIELD_W-1:0] tok_rows_in,
    output logic                   tok_valid_out,
    output logic [COL_W-1:0]       tok_col_out,
    output logic [ROW_FIELD_W-1:0] tok_rows_out,
    output result_t                res
);

    localparam int A_IDX = 2 * PAIR_INDEX;
    localparam int B_IDX = 2 * PAIR_INDEX + 1;

    logic                   tok_valid_reg;
    logic [COL_W-1:0]       tok_col_reg;
    logic [ROW_FIELD_W-1:0] tok_rows_reg;

    logic [COUNT_BITS-1:0]  count_reg [COLUMN_COUNT];
    logic                   prev_a_reg [COLUMN_COUNT];
    logic                   prev_b_reg [COLUMN_COUNT];

    logic                   a_now;
    logic                   b_now;
    logic                   a_was;
    logic                   b_was;
    logic                   dec;
    logic                   inc;
    logic [COUNT_BITS-1:0]  count_next;
    logic [31:0]            enc_full;

    // Rows above the sampled input width always read low.
    generate
        if (A_IDX < ROW_FIELD_W) begin : g_a_in
            assign a_now = tok_rows_reg[A_IDX];
        end else begin : g_a_low
            assign a_now = 1'b0;
        end
        if (B_IDX < ROW_FIELD_W) begin : g_b_in
            assign b_now = tok_rows_reg[B_IDX];
        end else begin : g_b_low
            assign b_now = 1'b0;
        end
    endgenerate

    // Edge detection against the levels seen on the last visit of this column.
    always_comb begin
        a_was = prev_a_reg[tok_col_reg];
        b_was = prev_b_reg[tok_col_reg];
        dec   = b_was && !b_now && a_now;
        inc   = !dec && a_was && !a_now && b_now;
        if (dec) begin
            count_next = count_reg[tok_col_reg] - COUNT_BITS'(1);
        end else if (inc) begin
            count_next = count_reg[tok_col_reg] + COUNT_BITS'(1);
        end else begin
            count_next = count_reg[tok_col_reg];
        end
    end

    // Result item for the token held in this cell.
    always_comb begin
        enc_full          = 32'(PAIR_INDEX * COLUMN_COUNT) + 32'(tok_col_reg);
        res.drive_column  = COL_FIELD_W'(32'(tok_col_reg));
        res.encoder_index = enc_full[ENC_FIELD_W-1:0];
        res.count_value   = COUNT_FIELD_W'(count_next);
        res.step          = dec ? STEP_DEC : (inc ? STEP_INC : STEP_NONE);
        res.last_of_tick  = (PAIR_INDEX == PAIR_COUNT - 1);
    end

    // Token register: moves one cell along the chain on each advance.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_valid_reg <= 1'b0;
        end else if (advance) begin
            tok_valid_reg <= tok_valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            tok_col_reg  <= tok_col_in;
            tok_rows_reg <= tok_rows_in;
        end
    end

    // Per-column state of this pair, updated when the token leaves the cell.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < COLUMN_COUNT; c++) begin
                count_reg[c]  <= '0;
                prev_a_reg[c] <= 1'b0;
                prev_b_reg[c] <= 1'b0;
            end
        end else if (advance && tok_valid_reg) begin
            count_reg[tok_col_reg]  <= count_next;
            prev_a_reg[tok_col_reg] <= a_now;
            prev_b_reg[tok_col_reg] <= b_now;
        end
    end

    assign tok_valid_out = tok_valid_reg;
    assign tok_col_out   = tok_col_reg;
    assign tok_rows_out  = tok_rows_reg;

endmodule

### rtl/matrix_scanned_quadrature_decoder.sv
// Top level of the matrix-scanned quadrature decoder.
// Depends on msqd_pkg and msqd_cell.
//
// Usage: each input item on the s_ channel is one scan tick and carries the
// row levels sampled while the next column is driven low. The column advances
// cyclically, and the first tick after reset uses column 0. Each row pair on
// each column is one encoder. The m_ channel gives one result item per row
// pair, ROW_COUNT/2 items per tick, with tlast on the final one.
// Each result passes from the token register of its cell into the output
// register, from which the m_ channel gives it.
// Throughput: a tick passes through the chain of row-pair cells in order, and
// the next tick is accepted in the cycle the current one leaves the last cell,
// so without a stall ticks follow each other without gaps.
// Reset: counts and stored rows clear to zero, the column points at the last
// column, and no item is held.
// Stall: when m_tready is low while a result waits, the whole chain holds and
// s_tready stays low for as long as the stall lasts; nothing is lost.
module matrix_scanned_quadrature_decoder import msqd_pkg::*; #(
    parameter int ROW_COUNT    = 8,
    parameter int COLUMN_COUNT = 4,
    parameter int COUNT_BITS   = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: row_levels[7:0]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // m_tdata: drive_column[1:0], encoder_index[5:2], count_value[21:6], step[23:22]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic        m_tlast
);

    localparam int PAIR_COUNT = ROW_COUNT / 2;
    localparam int COL_W      = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;

    logic [COL_W-1:0]       scan_col_reg;
    logic [COL_W-1:0]       scan_col_next;

    logic [PAIR_COUNT:0]    tok_valid;
    logic [COL_W-1:0]       tok_col  [PAIR_COUNT+1];
    logic [ROW_FIELD_W-1:0] tok_rows [PAIR_COUNT+1];
    result_t                res [PAIR_COUNT];

    logic                   advance;
    logic                   busy;
    logic                   accept;
    logic                   any_valid;
    result_t                sel;

    logic                   m_tvalid_reg;
    result_t                out_reg;

    // The chain moves whenever the output register is free or being drained.
    assign advance = !m_tvalid_reg || m_tready;

    // A new tick enters only when no token remains before the last cell.
    always_comb begin
        busy = 1'b0;
        for (int p = 0; p < PAIR_COUNT - 1; p++) begin
            busy = busy | tok_valid[p+1];
        end
    end

    assign s_tready = advance && !busy;
    assign accept   = s_tvalid && s_tready;

    // Cyclic column counter.
    always_comb begin
        if (32'(scan_col_reg) >= 32'(COLUMN_COUNT - 1)) begin
            scan_col_next = '0;
        end else begin
            scan_col_next = scan_col_reg + COL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_col_reg <= COL_W'(COLUMN_COUNT - 1);
        end else if (accept) begin
            scan_col_reg <= scan_col_next;
        end
    end

    // Chain input.
    assign tok_valid[0] = accept;
    assign tok_col[0]   = scan_col_next;
    assign tok_rows[0]  = s_tdata;

    // Row of cells, one per row pair.
    generate
        for (genvar p = 0; p < PAIR_COUNT; p++) begin : g_cell
            msqd_cell #(
                .PAIR_INDEX   (p),
                .PAIR_COUNT   (PAIR_COUNT),
                .COLUMN_COUNT (COLUMN_COUNT),
                .COUNT_BITS   (COUNT_BITS),
                .COL_W        (COL_W)
            ) u_cell (
                .aclk          (aclk),
                .aresetn       (aresetn),
                .advance       (advance),
                .tok_valid_in  (tok_valid[p]),
                .tok_col_in    (tok_col[p]),
                .tok_rows_in   (tok_rows[p]),
                .tok_valid_out (tok_valid[p+1]),
                .tok_col_out   (tok_col[p+1]),
                .tok_rows_out  (tok_rows[p+1]),
                .res           (res[p])
            );
        end
    endgenerate

    // Only one token lives in the chain, so pick the cell that holds it.
    always_comb begin
        any_valid = 1'b0;
        sel       = res[0];
        for (int p = 0; p < PAIR_COUNT; p++) begin
            if (tok_valid[p+1]) begin
                any_valid = 1'b1;
                sel       = res[p];
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= any_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= sel;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_reg.step, out_reg.count_value,
                       out_reg.encoder_index, out_reg.drive_column};
    assign m_tlast  = out_reg.last_of_tick;

`ifndef SYNTHESIS
    // At most one tick is in flight along the chain.
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tok_valid[PAIR_COUNT:1]))
        else $error("more than one token in the cell chain");

    // An accepted tick lands in the first cell.
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> tok_valid[1])
        else $error("accepted tick did not enter the first cell");

    // The last cell hands out the final result of the tick.
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && tok_valid[PAIR_COUNT]) |=> (m_tvalid && m_tlast))
        else $error("final result of a tick missing or unmarked");

    // A result that is not the last of its tick is followed by more of it.
    a_more: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (|tok_valid[PAIR_COUNT:1]))
        else $error("tick ended without its final result");
`endif

endmodule
